// File: hw/rtl/nearest_point_association_core_macros.svh
// assertion macros for the nearest point association core
// used by files that check their own control logic; needs clk and rst in scope
`ifndef NEAREST_POINT_ASSOCIATION_CORE_MACROS_SVH
`define NEAREST_POINT_ASSOCIATION_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define NPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define NPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/npa_pkg.sv
// shared types and constants for the nearest point association core
// no dependencies
`timescale 1ns / 1ps

package npa_pkg;

  localparam int MAX_REFERENCE_POINTS = 1024;
  localparam int ADDR_W               = $clog2(MAX_REFERENCE_POINTS);
  localparam int CNT_W                = $clog2(MAX_REFERENCE_POINTS + 1);
  localparam int COORD_W              = 16;
  localparam int POINT_W              = 2 * COORD_W;
  localparam int SQ_W                 = 2 * COORD_W;
  localparam int DIST_W               = 34;
  localparam int MATCH_INDEX_W        = 10;
  localparam int MODE_W               = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2
  } npa_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUSH
  } npa_state_t;

  // stored point entering the distance unit
  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] idx;
  } npa_tag_t;

  // squared distance leaving the distance unit
  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] idx;
    logic [DIST_W-1:0] sq_dist;
  } npa_dres_t;

endpackage

// File: hw/rtl/npa_if.sv
// request and response channel interfaces of the nearest point association core
// depends on npa_pkg
`timescale 1ns / 1ps

interface npa_req_if;
  import npa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;

  modport source (output valid, mode, point_x, point_y, input ready);
  modport sink   (input valid, mode, point_x, point_y, output ready);
endinterface

interface npa_rsp_if;
  import npa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MATCH_INDEX_W-1:0] match_index;
  logic [DIST_W-1:0]        nearest_sq_distance;
  logic                     store_empty;
  logic                     append_overflow;

  modport source (output valid, match_index, nearest_sq_distance, store_empty,
                  append_overflow, input ready);
  modport sink   (input valid, match_index, nearest_sq_distance, store_empty,
                  append_overflow, output ready);
endinterface

// File: hw/rtl/npa_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module npa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/npa_dist.sv
// pipelined squared distance unit: abs difference, square, sum
// depends on npa_pkg
`timescale 1ns / 1ps

module npa_dist (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [npa_pkg::COORD_W-1:0] qx,
  input  logic signed [npa_pkg::COORD_W-1:0] qy,
  input  logic [npa_pkg::POINT_W-1:0]        ref_pt,
  input  npa_pkg::npa_tag_t                  tag_in,
  output npa_pkg::npa_dres_t                 dres,
  output logic                               busy
);
  import npa_pkg::*;

  logic signed [COORD_W-1:0] rx, ry;
  logic signed [COORD_W:0]   dx, dy, dx_neg, dy_neg;
  logic [COORD_W-1:0]        ax_c, ay_c;

  logic                v1, v2, v3;
  logic [ADDR_W-1:0]   i1, i2, i3;
  logic [COORD_W-1:0]  ax, ay;
  logic [SQ_W-1:0]     sx, sy;
  logic [DIST_W-1:0]   dsum;

  always_comb begin
    rx     = ref_pt[COORD_W-1:0];
    ry     = ref_pt[POINT_W-1:COORD_W];
    dx     = {qx[COORD_W-1], qx} - {rx[COORD_W-1], rx};
    dy     = {qy[COORD_W-1], qy} - {ry[COORD_W-1], ry};
    dx_neg = -dx;
    dy_neg = -dy;
    // magnitude of a 17-bit difference always fits in 16 bits
    ax_c   = dx[COORD_W] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
    ay_c   = dy[COORD_W] ? dy_neg[COORD_W-1:0] : dy[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= tag_in.vld;
      v2 <= v1;
      v3 <= v2;
    end
    i1   <= tag_in.idx;
    ax   <= ax_c;
    ay   <= ay_c;
    i2   <= i1;
    sx   <= ax * ax;
    sy   <= ay * ay;
    i3   <= i2;
    dsum <= DIST_W'(sx) + DIST_W'(sy);
  end

  assign dres.vld     = v3;
  assign dres.idx     = i3;
  assign dres.sq_dist = dsum;
  assign busy         = v1 | v2 | v3;

endmodule

// File: hw/rtl/nearest_point_association_core.sv
// nearest point association core: sequencer, reference store and best-match tracking
// depends on npa_pkg, npa_if, npa_ram, npa_dist and the core macro header
`timescale 1ns / 1ps

// usage:
//   req channel carries one transaction per command: mode clear, append or query,
//   plus a signed 16-bit point. rsp channel returns one transaction per append
//   and per query; clear and the unused mode code return nothing.
//   append stores the point at the next free slot (up to 1024 points) and
//   answers with append_overflow set when the store was already full.
//   query walks every stored point in index order through the distance unit
//   and answers with the lowest index of minimum squared distance; an empty
//   store answers index 0, distance 0 with store_empty set.
//   an append or an empty query goes straight to the push state, which loads
//   the output register; a query with stored points scans first, with one ram
//   read per stored point, a 3-stage distance pipeline and a compare stage.
//   req.ready is high only while the sequencer is idle; a clear stays idle, an
//   append passes the push state and a query the scan and push states before the
//   next command is taken. the result sits in an output register, so a stalled rsp
//   side does not block a new request until the next result has to be handed over.
//   reset empties the store (stored contents are not cleared) and drops any
//   pending result.

module nearest_point_association_core (
  input logic      clk,
  input logic      rst,
  npa_req_if.sink  req,
  npa_rsp_if.source rsp
);
  import npa_pkg::*;
  `include "nearest_point_association_core_macros.svh"

  npa_state_t          state, state_next;
  npa_mode_t           mode;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    issue;
  logic                acc, issue_go, push_go, ram_we, full, scan_done;

  logic signed [COORD_W-1:0] qx, qy;
  logic [POINT_W-1:0]  rd_data;
  npa_tag_t            tag;
  npa_dres_t           dres;
  logic                dist_busy;

  logic [ADDR_W-1:0]   best_idx;
  logic [DIST_W-1:0]   best_dist;
  logic                res_empty, res_ovf;

  logic                     o_vld;
  logic [MATCH_INDEX_W-1:0] o_idx;
  logic [DIST_W-1:0]        o_dist;
  logic                     o_empty, o_ovf;

  assign mode      = npa_mode_t'(req.mode);
  assign full      = (count == CNT_W'(MAX_REFERENCE_POINTS));
  assign scan_done = (issue == count) && !tag.vld && !dist_busy;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          unique case (mode)
            MODE_APPEND: state_next = ST_PUSH;
            MODE_QUERY:  state_next = (count == '0) ? ST_PUSH : ST_SCAN;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: if (scan_done) state_next = ST_PUSH;
      ST_PUSH: if (push_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready = (state == ST_IDLE);
    acc       = req.valid && (state == ST_IDLE);
    issue_go  = (state == ST_SCAN) && (issue != count);
    push_go   = (state == ST_PUSH) && (!o_vld || rsp.ready);
    ram_we    = acc && (mode == MODE_APPEND) && !full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      tag.vld <= 1'b0;
    end else begin
      state   <= state_next;
      tag.vld <= issue_go;
      if (acc && mode == MODE_CLEAR) begin
        count <= '0;
      end else if (ram_we) begin
        count <= count + 1'b1;
      end
    end
    tag.idx <= issue[ADDR_W-1:0];
    if (acc) begin
      issue <= '0;
      qx    <= req.point_x;
      qy    <= req.point_y;
    end else if (issue_go) begin
      issue <= issue + 1'b1;
    end
  end

  npa_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_REFERENCE_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({req.point_y, req.point_x}),
    .re    (issue_go),
    .raddr (issue[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  npa_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .qx     (qx),
    .qy     (qy),
    .ref_pt (rd_data),
    .tag_in (tag),
    .dres   (dres),
    .busy   (dist_busy)
  );

  // best match; strict less keeps the first minimum
  always_ff @(posedge clk) begin
    if (acc) begin
      best_idx  <= '0;
      best_dist <= '0;
      res_empty <= (mode == MODE_QUERY) && (count == '0);
      res_ovf   <= (mode == MODE_APPEND) && full;
    end else if (dres.vld && (dres.idx == '0 || dres.sq_dist < best_dist)) begin
      best_idx  <= dres.idx;
      best_dist <= dres.sq_dist;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (push_go) begin
      o_vld <= 1'b1;
    end else if (rsp.ready) begin
      o_vld <= 1'b0;
    end
    if (push_go) begin
      o_idx   <= MATCH_INDEX_W'(best_idx);
      o_dist  <= best_dist;
      o_empty <= res_empty;
      o_ovf   <= res_ovf;
    end
  end

  assign rsp.valid               = o_vld;
  assign rsp.match_index         = o_idx;
  assign rsp.nearest_sq_distance = o_dist;
  assign rsp.store_empty         = o_empty;
  assign rsp.append_overflow     = o_ovf;

  `NPA_ASSERT_IMP(a_idle_pipe_empty, state == ST_IDLE, !tag.vld && !dist_busy, "pipeline active while idle")
  `NPA_ASSERT_IMP(a_count_bound, ram_we, !full, "store written while full")
  `NPA_ASSERT_NEXT(a_empty_query, acc && mode == MODE_QUERY && count == '0, state == ST_PUSH && res_empty, "empty query not answered directly")
  `NPA_ASSERT_NEXT(a_scan_nonempty, state == ST_SCAN && scan_done, !res_empty && !res_ovf, "scan result carries flags")

endmodule
